// ===== hw/rtl/apid_pkg.sv =====
package apid_pkg;

  // APB geometry
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 32;

  // Field widths
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned GAIN_W  = 24;
  localparam int unsigned DRIVE_W = 15;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_GAIN_P = 2'd0;
  localparam logic [1:0] REG_GAIN_I = 2'd1;
  localparam logic [1:0] REG_GAIN_D = 2'd2;

  // Gain reset values, Q15.8
  localparam logic signed [GAIN_W-1:0] GAIN_P_RST = -24'sd409600;
  localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 24'sd0;
  localparam logic signed [GAIN_W-1:0] GAIN_D_RST = -24'sd217600;

  // Integral clamp, 500.0 deg in Q.8
  localparam logic signed [18:0] SUM_LIMIT = 19'sd128000;
  localparam logic signed [17:0] ERR_LIMIT = 18'sd98304;

  // Output limits
  localparam logic signed [DRIVE_W-1:0] LIMIT_WIDE   = 15'sd10000;
  localparam logic signed [DRIVE_W-1:0] LIMIT_NARROW = 15'sd8500;

endpackage

// ===== hw/rtl/apid_if.sv =====
// Input channel: one controller sample per transaction
interface apid_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] measured_angle;
  logic signed [15:0] zero_offset;
  logic signed [15:0] target_angle;
  logic               wide_limit;
  logic               halve_output;

  modport source (
    output valid, measured_angle, zero_offset, target_angle, wide_limit, halve_output,
    input  ready
  );
  modport sink (
    input  valid, measured_angle, zero_offset, target_angle, wide_limit, halve_output,
    output ready
  );
endinterface

// Result channel: one drive value per transaction
interface apid_out_if;
  logic               valid;
  logic               ready;
  logic signed [14:0] drive_value;

  modport source (output valid, drive_value, input ready);
  modport sink   (input  valid, drive_value, output ready);
endinterface

// ===== hw/rtl/angle_pid_with_output_halving.sv =====
// Angle-loop PID step with output saturation and optional halving.
//
// Channels: in_chan carries one sample (measured angle, zero offset and
// target, Q7.8 degrees, plus the wide_limit and halve_output flags) per
// transaction; out_chan returns exactly one drive_value per sample, in order.
// The three gains (Q15.8) sit on an APB port at 0x0, 0x4, 0x8; write them
// only while the block is idle. pready is tied high.
//
// Throughput: one sample per cycle while the output is not stalled, set
// by a five-register pipeline (input, error/integral, products,
// accumulate, output) with three parallel multipliers (24x18, 24x18,
// 24x19) in one stage. The integral and previous-error state update in
// the second stage, so consecutive samples chain correctly.
//
// Reset (rst_n low, synchronous): pipeline empty, integral and previous
// error cleared, gains back to their defaults.
// Stall: each stage holds while full and blocked; in_chan.ready drops only
// once every stage, the output register included, holds a sample and out_chan.ready is low.
module angle_pid_with_output_halving (
  input  logic                          clk,
  input  logic                          rst_n,
  apid_in_if.sink                       in_chan,
  apid_out_if.source                    out_chan,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [apid_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [apid_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [apid_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                          cfg_pready
);
  import apid_pkg::*;

  // ---------------- configuration ----------------
  logic signed [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r;
  logic                     cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= GAIN_P_RST;
      gain_i_r <= GAIN_I_RST;
      gain_d_r <= GAIN_D_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_GAIN_P: gain_p_r <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_I: gain_i_r <= cfg_pwdata[GAIN_W-1:0];
        REG_GAIN_D: gain_d_r <= cfg_pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // readback, sign-extended
  always_comb begin
    case (cfg_paddr[3:2])
      REG_GAIN_P: cfg_prdata = {{(CFG_DW-GAIN_W){gain_p_r[GAIN_W-1]}}, gain_p_r};
      REG_GAIN_I: cfg_prdata = {{(CFG_DW-GAIN_W){gain_i_r[GAIN_W-1]}}, gain_i_r};
      REG_GAIN_D: cfg_prdata = {{(CFG_DW-GAIN_W){gain_d_r[GAIN_W-1]}}, gain_d_r};
      default:    cfg_prdata = '0;
    endcase
  end

  // ---------------- pipeline flow control ----------------
  logic v1_r, v2_r, v3_r, v4_r, ov_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic load1, load2, load3, load4, load_out;

  assign rdy_out  = !ov_r || out_chan.ready;
  assign rdy4     = !v4_r || rdy_out;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;

  assign load1    = in_chan.valid && rdy1;
  assign load2    = v1_r && rdy2;
  assign load3    = v2_r && rdy3;
  assign load4    = v3_r && rdy4;
  assign load_out = v4_r && rdy_out;

  assign in_chan.ready  = rdy1;
  assign out_chan.valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r <= in_chan.valid;
      if (rdy2)    v2_r <= v1_r;
      if (rdy3)    v3_r <= v2_r;
      if (rdy4)    v4_r <= v3_r;
      if (rdy_out) ov_r <= v4_r;
    end
  end

  // ---------------- stage 1: input register ----------------
  logic signed [ANGLE_W-1:0] angle1_r, zero1_r, target1_r;
  logic                      wide1_r, halve1_r;

  always_ff @(posedge clk) begin
    if (load1) begin
      angle1_r  <= in_chan.measured_angle;
      zero1_r   <= in_chan.zero_offset;
      target1_r <= in_chan.target_angle;
      wide1_r   <= in_chan.wide_limit;
      halve1_r  <= in_chan.halve_output;
    end
  end

  // ---------------- stage 2: error, integral, difference ----------------
  logic signed [17:0] error_sum_r, prev_err_r;
  logic signed [17:0] err_c, sum_c;
  logic signed [18:0] sum_raw_c, diff_c;

  always_comb begin
    err_c     = 18'(target1_r) + 18'(zero1_r) - 18'(angle1_r);
    sum_raw_c = 19'(error_sum_r) + 19'(err_c);
    if (sum_raw_c >= SUM_LIMIT)       sum_c = 18'(SUM_LIMIT);
    else if (sum_raw_c <= -SUM_LIMIT) sum_c = 18'(-SUM_LIMIT);
    else                              sum_c = sum_raw_c[17:0];
    diff_c    = 19'(err_c) - 19'(prev_err_r);
  end

  logic signed [17:0] err2_r, sum2_r;
  logic signed [18:0] diff2_r;
  logic               wide2_r, halve2_r;

  // loop state advances once per sample, in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_sum_r <= '0;
      prev_err_r  <= '0;
    end else if (load2) begin
      error_sum_r <= sum_c;
      prev_err_r  <= err_c;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      err2_r   <= err_c;
      sum2_r   <= sum_c;
      diff2_r  <= diff_c;
      wide2_r  <= wide1_r;
      halve2_r <= halve1_r;
    end
  end

  // ---------------- stage 3: gain products ----------------
  logic signed [41:0] prod_p_c, prod_i_c;
  logic signed [42:0] prod_d_c;

  assign prod_p_c = 42'(gain_p_r) * 42'(err2_r);
  assign prod_i_c = 42'(gain_i_r) * 42'(sum2_r);
  assign prod_d_c = 43'(gain_d_r) * 43'(diff2_r);

  logic signed [41:0] prod_p3_r, prod_i3_r;
  logic signed [42:0] prod_d3_r;
  logic               wide3_r, halve3_r;

  always_ff @(posedge clk) begin
    if (load3) begin
      prod_p3_r <= prod_p_c;
      prod_i3_r <= prod_i_c;
      prod_d3_r <= prod_d_c;
      wide3_r   <= wide2_r;
      halve3_r  <= halve2_r;
    end
  end

  // ---------------- stage 4: accumulate (Q.16) ----------------
  logic signed [44:0] acc_c;
  assign acc_c = 45'(prod_p3_r) + 45'(prod_i3_r) + 45'(prod_d3_r);

  logic signed [44:0] acc4_r;
  logic               wide4_r, halve4_r;

  always_ff @(posedge clk) begin
    if (load4) begin
      acc4_r   <= acc_c;
      wide4_r  <= wide3_r;
      halve4_r <= halve3_r;
    end
  end

  // ---------------- stage 5: truncate, clamp, halve ----------------
  logic signed [28:0]        whole_c;
  logic signed [DRIVE_W-1:0] limit_c, clamp_c, drive_c;

  always_comb begin
    // floor shift, then step toward zero when negative with a fraction
    whole_c = acc4_r[44:16] + 29'(acc4_r[44] && (acc4_r[15:0] != '0));
    limit_c = wide4_r ? LIMIT_WIDE : LIMIT_NARROW;
    if (whole_c > 29'(limit_c))       clamp_c = limit_c;
    else if (whole_c < -29'(limit_c)) clamp_c = -limit_c;
    else                              clamp_c = whole_c[DRIVE_W-1:0];
    // halve toward zero
    if (halve4_r) drive_c = (clamp_c + $signed(DRIVE_W'(clamp_c[DRIVE_W-1]))) >>> 1;
    else          drive_c = clamp_c;
  end

  logic signed [DRIVE_W-1:0] drive_r;

  always_ff @(posedge clk) begin
    if (load_out) drive_r <= drive_c;
  end

  assign out_chan.drive_value = drive_r;

`ifndef SYNTHESIS
  // integral stays inside its clamp
  a_sum_range: assert property (@(posedge clk) disable iff (!rst_n)
    (error_sum_r <= 18'(SUM_LIMIT)) && (error_sum_r >= 18'(-SUM_LIMIT)))
    else $error("error_sum out of range");

  // previous error stays inside the reachable error range
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    (prev_err_r <= ERR_LIMIT) && (prev_err_r >= -ERR_LIMIT))
    else $error("previous error out of range");

  // loop state only moves when a sample enters stage 2
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load2 |=> $stable(error_sum_r) && $stable(prev_err_r))
    else $error("loop state changed without a sample");

  // delivered drive never exceeds the wide limit
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> (drive_r <= LIMIT_WIDE) && (drive_r >= -LIMIT_WIDE))
    else $error("drive value out of range");

  // a sample in the last stage reaches the output register when it is free
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && (!ov_r || out_chan.ready)) |=> ov_r)
    else $error("result lost between accumulate and output");
`endif

endmodule
